// File: hdl/access_rule_table_match_defines.svh
// Assertion macros for the access rule table checker.
// Depends on nothing; the including module must have clk_i and rst_ni.
`ifndef ACCESS_RULE_TABLE_MATCH_DEFINES_SVH
`define ACCESS_RULE_TABLE_MATCH_DEFINES_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ARTM_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the default clock and reset names.
`define ARTM_ASSERT(lbl, prop, msg) \
  `ARTM_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// File: hdl/artm_pkg.sv
// Shared types and constants for the access rule table match block.
// Has no dependencies; used by every module of the block.
package artm_pkg;

  localparam int unsigned DEFAULT_RULE_DEPTH = 64;
  localparam int unsigned ID_W = 32;
  localparam int unsigned STORED_W = 7;

  localparam logic OP_CHECK = 1'b0;
  localparam logic OP_ADD   = 1'b1;

  typedef struct packed {
    logic            operation;
    logic [ID_W-1:0] subject_id;
    logic [ID_W-1:0] object_id;
    logic [ID_W-1:0] action_mask;
    logic            grant_bit;
  } artm_req_t;

  typedef struct packed {
    logic                allowed;
    logic                accepted;
    logic [STORED_W-1:0] rules_stored;
  } artm_rsp_t;

  typedef struct packed {
    logic [ID_W-1:0] subject;
    logic [ID_W-1:0] object;
    logic [ID_W-1:0] actions;
    logic            grant;
  } artm_rule_t;

  typedef struct packed {
    logic load;
    logic add;
    logic scan_rd;
  } artm_cmd_t;

  typedef struct packed {
    logic is_add;
    logic scan_needed;
    logic last;
  } artm_sts_t;

endpackage

// File: hdl/artm_dp.sv
// Datapath of the access rule table: rule memory, rule count, request
// register, enforce register and the match compare. Depends on artm_pkg.
module artm_dp
  import artm_pkg::*;
#(
  parameter int unsigned RULE_DEPTH = DEFAULT_RULE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_valid_i,
  input  logic      cfg_data_i,
  input  artm_req_t req_i,
  input  artm_cmd_t cmd_i,
  output artm_sts_t sts_o,
  output artm_rsp_t rsp_o
);

  localparam int unsigned IdxW = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(RULE_DEPTH + 1);

  artm_rule_t             mem_q [RULE_DEPTH];
  artm_rule_t             rd_q;
  artm_req_t              req_q;
  logic                   en_q;
  logic                   enforce_q;
  logic [CntW-1:0]        cnt_q;
  logic [IdxW-1:0]        rd_idx_q;
  logic                   hit_vld_q;
  logic                   verdict_q;
  logic                   accepted_q;
  logic                   has_room;
  logic                   wr_en;
  logic                   hit;
  artm_rule_t             wr_rule;
  logic [CntW+STORED_W-1:0] cnt_ext;

  assign has_room = cnt_q < CntW'(RULE_DEPTH);
  assign wr_en    = cmd_i.add && has_room;

  assign wr_rule.subject = req_q.subject_id;
  assign wr_rule.object  = req_q.object_id;
  assign wr_rule.actions = req_q.action_mask;
  assign wr_rule.grant   = req_q.grant_bit;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[cnt_q[IdxW-1:0]] <= wr_rule;
    end
    rd_q <= mem_q[rd_idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
      en_q  <= enforce_q;
    end
  end

  assign hit = hit_vld_q &&
               (rd_q.subject == req_q.subject_id) &&
               (rd_q.object == req_q.object_id) &&
               ((rd_q.actions & req_q.action_mask) != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enforce_q  <= 1'b0;
      cnt_q      <= '0;
      rd_idx_q   <= '0;
      hit_vld_q  <= 1'b0;
      verdict_q  <= 1'b0;
      accepted_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        enforce_q <= cfg_data_i;
      end
      if (wr_en) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      if (cmd_i.load) begin
        rd_idx_q <= '0;
      end else if (cmd_i.scan_rd) begin
        rd_idx_q <= rd_idx_q + IdxW'(1);
      end
      hit_vld_q <= cmd_i.scan_rd;
      if (cmd_i.load) begin
        verdict_q <= 1'b0;
      end else if (hit) begin
        verdict_q <= rd_q.grant;
      end
      if (cmd_i.load) begin
        accepted_q <= 1'b0;
      end else if (cmd_i.add) begin
        accepted_q <= has_room;
      end
    end
  end

  assign sts_o.is_add      = (req_q.operation == OP_ADD);
  assign sts_o.scan_needed = (req_q.operation == OP_CHECK) && en_q && (cnt_q != '0);
  assign sts_o.last        = (CntW'(rd_idx_q) + CntW'(1)) == cnt_q;

  assign cnt_ext = {{STORED_W{1'b0}}, cnt_q};

  assign rsp_o.allowed      = (req_q.operation == OP_CHECK) && (!en_q || verdict_q);
  assign rsp_o.accepted     = accepted_q;
  assign rsp_o.rules_stored = cnt_ext[STORED_W-1:0];

endmodule

// File: hdl/artm_ctrl.sv
// Controller state machine of the access rule table: sequences request
// capture, rule append and the table scan. Depends on artm_pkg.
module artm_ctrl
  import artm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  artm_sts_t sts_i,
  output artm_cmd_t cmd_o,
  output logic      busy,
  output logic      rsp_valid_o
);

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_DISPATCH = 5'b00010,
    ST_SCAN     = 5'b00100,
    ST_DRAIN    = 5'b01000,
    ST_RESP     = 5'b10000
  } state_e;

  state_e state_q;
  state_e state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (!sts_i.is_add && sts_i.scan_needed) begin
          state_d = ST_SCAN;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_SCAN: begin
        if (sts_i.last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o.load    = (state_q == ST_IDLE) && start;
  assign cmd_o.add     = (state_q == ST_DISPATCH) && sts_i.is_add;
  assign cmd_o.scan_rd = (state_q == ST_SCAN);

  assign busy        = (state_q != ST_IDLE);
  assign rsp_valid_o = (state_q == ST_RESP);

endmodule

// File: hdl/access_rule_table_match.sv
// Access rule table with last-match verdict. An add, a check with enforce off or a
// check on an empty table goes from the start transfer through dispatch to the result
// strobe; a check with enforce on and stored rules first scans the table, one rule read
// a cycle from the single memory read port, then drains the last compare. The next
// start is taken the cycle after the strobe.
// Reset empties the table and clears enforce; the receiver cannot stall results.
module access_rule_table_match
  import artm_pkg::*;
#(
  parameter int unsigned RULE_DEPTH = DEFAULT_RULE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  artm_req_t req_i,
  output logic      rsp_valid_o,
  output artm_rsp_t rsp_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_data_i
);

  artm_cmd_t cmd;
  artm_sts_t sts;

  assign cfg_ready_o = 1'b1;

  artm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy        (busy),
    .rsp_valid_o (rsp_valid_o)
  );

  artm_dp #(
    .RULE_DEPTH (RULE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_o       (rsp_o)
  );

endmodule

// File: hdl/artm_sva.sv
// Port-level checker for the access rule table, bound to the top level.
// Depends on artm_pkg and access_rule_table_match_defines.svh.
`include "access_rule_table_match_defines.svh"

module artm_sva
  import artm_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start,
  input logic      busy,
  input logic      rsp_valid_o,
  input artm_rsp_t rsp_o
);

  `ARTM_ASSERT(a_start_busy, start && !busy |=> busy && !rsp_valid_o, "start not taken")
  `ARTM_ASSERT(a_rsp_busy, rsp_valid_o |-> busy, "result strobe while not busy")
  `ARTM_ASSERT(a_rsp_then_idle, rsp_valid_o |=> !busy && !rsp_valid_o, "not idle after result")
  `ARTM_ASSERT(a_rsp_kind, rsp_valid_o |-> !(rsp_o.allowed && rsp_o.accepted), "both flags set")

endmodule

bind access_rule_table_match artm_sva u_artm_sva (.*);
